// ===== rtl/sfta_pkg.sv =====
// ----------------------------------------------------------------------------
// sfta_pkg : shared types and constants of the truncating float adder
// Operand unpack helper and the structs that travel down the pipeline.
// ----------------------------------------------------------------------------
package sfta_pkg;

	localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
	localparam logic [31:0] MANT_FIELD = 32'h3FFF_FF80;
	localparam logic [31:0] HIDDEN_ONE = 32'h4000_0000;
	localparam logic [9:0]  EXP_BIAS   = 10'd127;

	// unbiased exponents fit in 10 bits signed (-127..128, plus margin)
	typedef struct packed {
		logic signed [9:0] expo;
		logic [31:0]       frac;
	} operand_t;

	typedef struct packed {
		logic [31:0]       sum;
		logic signed [9:0] expo;
	} sum_t;

	function automatic operand_t unpack_op(input logic [31:0] bits);
		operand_t r;
		logic [31:0] f;
		if ((bits & ~SIGN_BIT) == 32'd0) begin
			r.expo = '0;
			r.frac = '0;
		end else begin
			r.expo = $signed({2'b00, bits[30:23]}) - $signed(EXP_BIAS);
			f = ((bits << 7) & MANT_FIELD) | HIDDEN_ONE;
			r.frac = bits[31] ? (32'd0 - f) : f;
		end
		return r;
	endfunction

endpackage

// ===== rtl/sfta_align.sv =====
// ----------------------------------------------------------------------------
// sfta_align : unpack, exponent compare, alignment shift and halved add
// Two register stages: unpack/compare, then shift and add.
// ----------------------------------------------------------------------------
module sfta_align import sfta_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_valid,
	input  logic [31:0] addend_a,
	input  logic [31:0] addend_b,
	output logic        valid_s2,
	output sum_t        res_s2
);
	operand_t ua, ub;
	logic signed [10:0] ediff;
	logic a_big;

	logic        valid_s1;
	logic [31:0] big_s1, small_s1;
	logic [5:0]  sh_s1;
	logic signed [9:0] e_s1;

	logic [31:0] shifted;

	assign ua = unpack_op(addend_a);
	assign ub = unpack_op(addend_b);
	assign ediff = 11'(ua.expo) - 11'(ub.expo);
	assign a_big = (ediff >= 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			big_s1   <= a_big ? ua.frac : ub.frac;
			small_s1 <= a_big ? ub.frac : ua.frac;
			e_s1     <= a_big ? ua.expo : ub.expo;
			// difference is at most 255; saturate at 32
			if (a_big) begin
				sh_s1 <= (ediff >= 11'sd32) ? 6'd32 : 6'(ediff);
			end else begin
				sh_s1 <= (-ediff >= 11'sd32) ? 6'd32 : 6'(-ediff);
			end
		end
	end

	assign shifted = sh_s1[5] ? {32{small_s1[31]}} : 32'($signed(small_s1) >>> sh_s1[4:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2.sum  <= 32'($signed(big_s1) >>> 1) + 32'($signed(shifted) >>> 1);
			res_s2.expo <= e_s1 + 10'sd1;
		end
	end

	ap_valid_flow: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2 == $past(valid_s1)) else $error("align valid lost");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_s2) && $stable(valid_s1)) else $error("align stall moved");
	ap_sh_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> sh_s1 <= 6'd32) else $error("shift out of range");
endmodule

// ===== rtl/sfta_norm.sv =====
// ----------------------------------------------------------------------------
// sfta_norm : magnitude, leading-one count, normalize and pack
// Two register stages: abs and count, then shift and pack.
// ----------------------------------------------------------------------------
module sfta_norm import sfta_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        valid_s2,
	input  sum_t        res_s2,
	output logic        valid_s4,
	output logic [31:0] sum_bits_s4
);
	logic [31:0] mag;
	logic [4:0]  lz;

	logic        valid_s3, zero_s3, sign_s3;
	logic [31:0] mag_s3;
	logic [4:0]  lz_s3;
	logic signed [9:0] e_s3;

	logic [31:0] nmag;
	logic [7:0]  bexp;

	assign mag = res_s2.sum[31] ? (32'd0 - res_s2.sum) : res_s2.sum;

	// shifts needed to bring the leading one to bit 30 (capped at 31)
	always_comb begin
		lz = 5'd31;
		for (int i = 0; i <= 30; i++) begin
			if (mag[i]) lz = 5'(30 - i);
		end
		if (mag[31]) lz = 5'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s3 <= (res_s2.sum == 32'd0);
			sign_s3 <= res_s2.sum[31];
			mag_s3  <= mag;
			lz_s3   <= lz;
			e_s3    <= res_s2.expo;
		end
	end

	assign nmag = mag_s3 << lz_s3;
	assign bexp = 8'(e_s3) - 8'(lz_s3) + 8'(EXP_BIAS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_bits_s4 <= zero_s3 ? 32'd0 : {sign_s3, bexp, nmag[29:7]};
		end
	end

	ap_flow: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s4 == $past(valid_s3)) else $error("norm valid lost");
	ap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s3 && zero_s3 |=> sum_bits_s4 == 32'd0) else $error("zero not +0");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !adv |=> valid_s4 && $stable(sum_bits_s4)) else $error("norm stall moved");
endmodule

// ===== rtl/single_float_truncating_adder.sv =====
// ----------------------------------------------------------------------------
// single_float_truncating_adder : pipelined truncating single-float adder
//
//  channel | valid   | stall   | word
//  input   | a_valid | a_stall | addend_a, addend_b
//  output  | valid   | stall   | sum_bits
//
// Four register stages: unpack/compare, align/add, abs/count, normalize/pack.
// One word per cycle sustained while the output is not stalled.
// The whole pipe advances together; a_stall follows the output stall when
// the last stage holds a word. Bubbles inside the pipe are not squeezed out.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module single_float_truncating_adder import sfta_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        a_valid,
	output logic        a_stall,
	input  logic [31:0] addend_a,
	input  logic [31:0] addend_b,
	output logic        valid,
	input  logic        stall,
	output logic [31:0] sum_bits
);
	logic   adv;
	logic   valid_s2;
	sum_t   res_s2;

	// pipe moves whenever the output slot is empty or being taken
	assign adv     = !valid || !stall;
	assign a_stall = !adv;

	sfta_align u_align (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(a_valid),
		.addend_a(addend_a), .addend_b(addend_b),
		.valid_s2(valid_s2), .res_s2(res_s2)
	);

	sfta_norm u_norm (
		.clk(clk), .arst_n(arst_n), .adv(adv), .valid_s2(valid_s2),
		.res_s2(res_s2), .valid_s4(valid), .sum_bits_s4(sum_bits)
	);

	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && stall |=> valid && $stable(sum_bits)) else $error("output word changed");
	ap_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		a_stall |-> valid && stall) else $error("spurious input stall");
	ap_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid |-> !a_stall) else $error("stall while empty");
endmodule
